// ===== hdl/rtc_datetime_normalizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// rtc datetime normalizer assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef RTC_DATETIME_NORMALIZER_TOP_MACROS_SVH
`define RTC_DATETIME_NORMALIZER_TOP_MACROS_SVH

// implication checked in the same cycle, ignored while in reset
`define RDN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// implication checked in the cycle after the antecedent, ignored while in reset
`define RDN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// implication checked on every edge, reset included
`define RDN_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/rdn_pkg.sv =====
// ----------------------------------------------------------------------------
// rdn_pkg
// shared types, constants and helpers of the rtc datetime normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdn_pkg;

  localparam int N_LANES   = 6;
  localparam int LANE_SEC  = 0;
  localparam int LANE_MIN  = 1;
  localparam int LANE_HOUR = 2;
  localparam int LANE_DAY  = 3;
  localparam int LANE_MON  = 4;
  localparam int LANE_YEAR = 5;

  localparam int STAT_BINARY_BIT = 2;
  localparam int STAT_24H_BIT    = 1;
  localparam int HOUR_PM_BIT     = 7;

  localparam logic [7:0] RESET_YEAR = 8'h26;

  localparam logic [6:0] LIM_LO [N_LANES] = '{7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd0};
  localparam logic [6:0] LIM_HI [N_LANES] = '{7'd59, 7'd59, 7'd23, 7'd31, 7'd12, 7'd99};

  typedef struct packed {
    logic binary;
    logic h24;
  } mode_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] bcd;
  } lane_res_t;

  typedef struct packed {
    logic       snapshot_valid;
    logic [7:0] yr_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hours_bcd;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;
  } result_t;

  // binary 0..127 to two bcd digits, exact for values up to 99
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 14'(v) * 14'd103;
    q    = prod[13:10];
    r    = v - 7'({q, 3'b000}) - 7'({q, 1'b0});
    return {q, r[3:0]};
  endfunction

endpackage

// ===== hdl/rtc_datetime_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// rtc_datetime_normalizer_top
// normalizes raw rtc datetime snapshots into validated 24-hour bcd
// ----------------------------------------------------------------------------
// usage:
//   input stream: in_tuser carries the status byte, in_tdata the six raw
//   field bytes. each accepted transaction yields exactly one output
//   transaction with the validity flag on out_tuser and the bcd fields on
//   out_tdata, or the default datetime when any field fails.
//   six decode lanes run side by side, one per field; the merge stage
//   reduces their flags and loads the single output register.
//   out_tvalid rises in the cycle after acceptance; throughput is one
//   transaction per cycle while out_tready is high, set by the one
//   output register. when the receiver stalls, the output holds and
//   in_tready drops until the held transaction is taken, so nothing is lost.
//   reset empties the output register and loads the default year 0x26.
//   cfg_wr_en writes cfg_wr_data to the default year; write only when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtc_datetime_normalizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // raw_seconds, raw_minutes, raw_hours, raw_day, raw_month, raw_year
  input  logic [47:0] in_tdata,
  // status_register
  input  logic [7:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // seconds_bcd, minutes_bcd, hours_bcd, day_bcd, month_bcd, yr_bcd, pad
  output logic [39:0] out_tdata,
  // snapshot_valid
  output logic        out_tuser
);
  import rdn_pkg::*;

  logic [7:0] default_year_r;
  logic [7:0] default_year_nxt;
  mode_t      mode;
  lane_res_t  lanes [N_LANES];
  result_t    res;

  assign default_year_nxt = cfg_wr_en ? cfg_wr_data : default_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_year_r <= RESET_YEAR;
    end else begin
      default_year_r <= default_year_nxt;
    end
  end

  assign mode.binary = in_tuser[STAT_BINARY_BIT];
  assign mode.h24    = in_tuser[STAT_24H_BIT];

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    rdn_lane u_lane (
      .raw       (in_tdata[8*g +: 8]),
      .mode      (mode),
      .hour_lane (1'(g == LANE_HOUR)),
      .lim_lo    (LIM_LO[g]),
      .lim_hi    (LIM_HI[g]),
      .res       (lanes[g])
    );
  end

  rdn_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .lanes        (lanes),
    .default_year (default_year_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res)
  );

  assign out_tdata = {1'b0, res.yr_bcd, res.month_bcd, res.day_bcd,
                      res.hours_bcd, res.minutes_bcd, res.seconds_bcd};
  assign out_tuser = res.snapshot_valid;

endmodule

// ===== hdl/rdn_lane.sv =====
// ----------------------------------------------------------------------------
// rdn_lane
// decodes one raw field byte, applies 12-hour fixup, range checks, re-encodes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdn_lane (
  input  logic [7:0]        raw,
  input  rdn_pkg::mode_t    mode,
  input  logic              hour_lane,
  input  logic [6:0]        lim_lo,
  input  logic [6:0]        lim_hi,
  output rdn_pkg::lane_res_t res
);
  import rdn_pkg::*;

  logic [7:0] field;
  logic [3:0] dig_lo;
  logic [3:0] dig_hi;
  logic       bad_digit;
  logic [7:0] dec;
  logic [7:0] adj;

  assign field     = hour_lane ? {1'b0, raw[6:0]} : raw;
  assign dig_lo    = field[3:0];
  assign dig_hi    = field[7:4];
  assign bad_digit = !mode.binary && ((dig_lo > 4'd9) || (dig_hi > 4'd9));
  assign dec       = mode.binary ? field
                   : ({1'b0, dig_hi, 3'b000} + {3'b000, dig_hi, 1'b0} + {4'b0000, dig_lo});

  always_comb begin
    adj = dec;
    if (hour_lane && !mode.h24) begin
      if (adj == 8'd12) begin
        adj = 8'd0;
      end
      if (raw[HOUR_PM_BIT] && (adj < 8'd12)) begin
        adj = adj + 8'd12;
      end
    end
  end

  assign res.ok  = !bad_digit && (adj >= {1'b0, lim_lo}) && (adj <= {1'b0, lim_hi});
  assign res.bcd = to_bcd(adj[6:0]);

endmodule

// ===== hdl/rdn_merge.sv =====
// ----------------------------------------------------------------------------
// rdn_merge
// combines lane results, substitutes defaults, holds the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdn_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  rdn_pkg::lane_res_t lanes [rdn_pkg::N_LANES],
  input  logic [7:0]         default_year,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rdn_pkg::result_t   out_res
);
  import rdn_pkg::*;

  logic    all_ok;
  result_t res_nxt;
  result_t res_r;
  logic    valid_r;
  logic    valid_nxt;

  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < N_LANES; i++) begin
      all_ok = all_ok & lanes[i].ok;
    end
  end

  always_comb begin
    res_nxt.snapshot_valid = all_ok;
    if (all_ok) begin
      res_nxt.seconds_bcd = lanes[LANE_SEC].bcd[6:0];
      res_nxt.minutes_bcd = lanes[LANE_MIN].bcd[6:0];
      res_nxt.hours_bcd   = lanes[LANE_HOUR].bcd[5:0];
      res_nxt.day_bcd     = lanes[LANE_DAY].bcd[5:0];
      res_nxt.month_bcd   = lanes[LANE_MON].bcd[4:0];
      res_nxt.yr_bcd      = lanes[LANE_YEAR].bcd;
    end else begin
      res_nxt.seconds_bcd = 7'h00;
      res_nxt.minutes_bcd = 7'h00;
      res_nxt.hours_bcd   = 6'h00;
      res_nxt.day_bcd     = 6'h01;
      res_nxt.month_bcd   = 5'h01;
      res_nxt.yr_bcd      = default_year;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/rdn_checker.sv =====
// ----------------------------------------------------------------------------
// rdn_checker
// port-level checks of the rtc datetime normalizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtc_datetime_normalizer_top_macros.svh"

module rdn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  `RDN_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `RDN_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n), !out_tvalid)
  `RDN_ASSERT_NOW(a_invalid_default, out_tvalid && !out_tuser, out_tdata[19:0] == 20'h0 && out_tdata[25:20] == 6'h01 && out_tdata[30:26] == 5'h01)
  `RDN_ASSERT_NOW(a_valid_digits, out_tvalid && out_tuser, out_tdata[3:0] <= 4'd9 && out_tdata[10:7] <= 4'd9 && out_tdata[17:14] <= 4'd9 && out_tdata[23:20] <= 4'd9 && out_tdata[29:26] <= 4'd9 && out_tdata[34:31] <= 4'd9 && out_tdata[38:35] <= 4'd9)
  `RDN_ASSERT_NEXT(a_accept_output, in_tvalid && in_tready, out_tvalid)

endmodule

bind rtc_datetime_normalizer_top rdn_checker u_rdn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
